[rtl/dpds_pkg.sv]
// Shared types, codes and helpers for the dual periodic deadline scheduler.
// No dependencies; imported by dpds_div and dual_periodic_deadline_scheduler.
package dpds_pkg;

  // Tick count width and period type (periods are always 1..4)
  localparam int TICK_W = 32;
  localparam int RAW_W  = 8;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [2:0]        period_t;
  typedef logic [RAW_W-1:0]  raw_t;

  localparam period_t PERIOD_MIN = 3'd1;
  localparam period_t PERIOD_MAX = 3'd4;

  // Item command codes; code three is a no-op
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ADVANCE = 2'd0;
  localparam cmd_t CMD_INIT    = 2'd1;
  localparam cmd_t CMD_APPLY   = 2'd2;

  // Configuration register indexes
  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_SIM_INTERVAL  = 1'b0;
  localparam cfg_idx_t CFG_PRES_INTERVAL = 1'b1;

  // Clamp a requested interval into 1..4
  function automatic period_t clamp_period(input raw_t raw);
    period_t p;
    if (raw == '0) begin
      p = PERIOD_MIN;
    end else if (raw > raw_t'(PERIOD_MAX)) begin
      p = PERIOD_MAX;
    end else begin
      p = raw[2:0];
    end
    return p;
  endfunction

endpackage

[rtl/dpds_div.sv]
// Bit-serial restoring divider: 32-bit dividend by a 1..4 period.
// One quotient bit per cycle. Depends on dpds_pkg.
module dpds_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dpds_pkg::tick_t  dividend,
  input  dpds_pkg::period_t divisor,
  output logic             done,
  output dpds_pkg::tick_t  quotient,
  output dpds_pkg::period_t remainder
);
  import dpds_pkg::*;

  localparam int CNT_W = $clog2(TICK_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TICK_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  period_t          dvsr;
  tick_t            quo;
  period_t          rem;

  // Trial subtract for the current step
  logic [3:0] trial;
  logic       fits;
  period_t    rem_next;

  always_comb begin
    trial = {rem, quo[TICK_W-1]};
    fits  = trial >= {1'b0, dvsr};
    if (fits) begin
      rem_next = 3'(trial - {1'b0, dvsr});
    end else begin
      rem_next = trial[2:0];
    end
  end

  // Step sequencer; done is registered and pulses in the cycle after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= {quo[TICK_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[rtl/dual_periodic_deadline_scheduler.sv]
// Dual periodic deadline scheduler: top level with sequencer and state (dpds_pkg, dpds_div).
// Init, apply and no-op items: result registered from ST_DONE once the output register is free.
// Advance items: computed by one shared 32-step bit-serial divider, run once
// per due schedule (simulation, then presentation); after the result, the next item is taken in ST_IDLE.
// One item in flight; a stalled full output register holds the sequencer.
// Synchronous active-high reset; no clearing pass.
module dual_periodic_deadline_scheduler (
  input  logic                clk,
  input  logic                rst,
  // item channel
  input  logic                item_valid,
  output logic                item_stall,
  input  dpds_pkg::cmd_t      command,
  input  dpds_pkg::tick_t     current_tick,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output dpds_pkg::tick_t     elapsed_ticks,
  output logic                sim_due,
  output dpds_pkg::tick_t     sim_missed,
  output logic                pres_due,
  output dpds_pkg::tick_t     pres_missed,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  dpds_pkg::cfg_idx_t  cfg_index,
  input  dpds_pkg::raw_t      cfg_data
);
  import dpds_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIM_START,
    ST_SIM_WAIT,
    ST_PRES_START,
    ST_PRES_WAIT,
    ST_DONE
  } state_t;

  state_t state;

  // Architectural state
  raw_t    sim_interval_raw;
  raw_t    pres_interval_raw;
  period_t sim_period;
  period_t pres_period;
  tick_t   next_sim_deadline;
  tick_t   next_pres_deadline;
  tick_t   last_tick;

  // Working copy of the item and its result
  tick_t   tick_r;
  tick_t   w_elapsed;
  logic    w_sim_due;
  tick_t   w_sim_missed;
  logic    w_pres_due;
  tick_t   w_pres_missed;

  // Shared divider
  logic    div_start;
  tick_t   div_dividend;
  period_t div_divisor;
  logic    div_done;
  tick_t   div_quo;
  period_t div_rem;

  tick_t   sim_diff;
  tick_t   pres_diff;
  tick_t   new_deadline;
  period_t sim_clamped;
  period_t pres_clamped;
  logic    item_accept;
  logic    out_free;

  assign cfg_ready   = 1'b1;
  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;

  assign sim_clamped  = clamp_period(sim_interval_raw);
  assign pres_clamped = clamp_period(pres_interval_raw);

  // Wrapping distance past each deadline
  assign sim_diff  = tick_r - next_sim_deadline;
  assign pres_diff = tick_r - next_pres_deadline;

  // Divider launch: only when the schedule is due (difference not negative)
  always_comb begin
    div_start    = 1'b0;
    div_dividend = sim_diff;
    div_divisor  = sim_period;
    if (state == ST_SIM_START) begin
      div_start = !sim_diff[TICK_W-1];
    end else if (state == ST_PRES_START) begin
      div_start    = !pres_diff[TICK_W-1];
      div_dividend = pres_diff;
      div_divisor  = pres_period;
    end
  end

  // deadline + (q+1)*p == now - r + p
  always_comb begin
    if (state == ST_PRES_WAIT) begin
      new_deadline = tick_r - tick_t'(div_rem) + tick_t'(pres_period);
    end else begin
      new_deadline = tick_r - tick_t'(div_rem) + tick_t'(sim_period);
    end
  end

  dpds_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sim_interval_raw  <= raw_t'(1);
      pres_interval_raw <= raw_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIM_INTERVAL:  sim_interval_raw  <= cfg_data;
        CFG_PRES_INTERVAL: pres_interval_raw <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, schedule state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      result_valid       <= 1'b0;
      sim_period         <= PERIOD_MIN;
      pres_period        <= PERIOD_MIN;
      next_sim_deadline  <= tick_t'(1);
      next_pres_deadline <= tick_t'(1);
      last_tick          <= '0;
    end else begin
      // Output register: loaded from ST_DONE, emptied when taken
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_accept) begin
            tick_r        <= current_tick;
            w_elapsed     <= (command == CMD_ADVANCE) ? current_tick - last_tick : '0;
            w_sim_due     <= 1'b0;
            w_sim_missed  <= '0;
            w_pres_due    <= 1'b0;
            w_pres_missed <= '0;
            state         <= (command == CMD_ADVANCE) ? ST_SIM_START : ST_DONE;
            unique case (command)
              CMD_ADVANCE: begin
                last_tick <= current_tick;
              end
              CMD_INIT: begin
                sim_period         <= sim_clamped;
                pres_period        <= pres_clamped;
                next_sim_deadline  <= current_tick + tick_t'(sim_clamped);
                next_pres_deadline <= current_tick + tick_t'(pres_clamped);
                last_tick          <= current_tick;
              end
              CMD_APPLY: begin
                if (sim_clamped != sim_period) begin
                  sim_period        <= sim_clamped;
                  next_sim_deadline <= current_tick + tick_t'(sim_clamped);
                end
                if (pres_clamped != pres_period) begin
                  pres_period        <= pres_clamped;
                  next_pres_deadline <= current_tick + tick_t'(pres_clamped);
                end
              end
              default: ;
            endcase
          end
        end

        ST_SIM_START: begin
          state <= sim_diff[TICK_W-1] ? ST_PRES_START : ST_SIM_WAIT;
        end

        ST_SIM_WAIT: begin
          if (div_done) begin
            w_sim_due         <= 1'b1;
            w_sim_missed      <= div_quo;
            next_sim_deadline <= new_deadline;
            state             <= ST_PRES_START;
          end
        end

        ST_PRES_START: begin
          state <= pres_diff[TICK_W-1] ? ST_DONE : ST_PRES_WAIT;
        end

        ST_PRES_WAIT: begin
          if (div_done) begin
            w_pres_due         <= 1'b1;
            w_pres_missed      <= div_quo;
            next_pres_deadline <= new_deadline;
            state              <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            elapsed_ticks <= w_elapsed;
            sim_due       <= w_sim_due;
            sim_missed    <= w_sim_missed;
            pres_due      <= w_pres_due;
            pres_missed   <= w_pres_missed;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/tb_dual_periodic_deadline_scheduler.sv]
// Self-checking testbench for dual_periodic_deadline_scheduler: directed table, then random
// phases with register rewrites, random idling on both channels, and an inline predictor.
// Depends on dpds_pkg and the dual_periodic_deadline_scheduler RTL.
module tb_dual_periodic_deadline_scheduler;
  import dpds_pkg::*;

  // Command code three has no name in the package; the block treats it as a no-op
  localparam cmd_t CMD_NOP = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    tick_t elapsed;
    logic  sim_due;
    tick_t sim_missed;
    logic  pres_due;
    tick_t pres_missed;
  } sched_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    cmd_t          cmd;
    tick_t         tick;
    raw_t          sim_raw;
    raw_t          pres_raw;
    bit            typed;
    sched_result_t want;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  item_valid;
  logic  item_stall;
  cmd_t  command;
  tick_t current_tick;
  logic  result_valid;
  logic  result_stall;
  tick_t elapsed_ticks;
  logic  sim_due;
  tick_t sim_missed;
  logic  pres_due;
  tick_t pres_missed;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  raw_t     cfg_data;

  // Predictor state: registers, periods, deadlines and the last advance tick
  raw_t    sim_raw_q;
  raw_t    pres_raw_q;
  period_t sim_per;
  period_t pres_per;
  tick_t   sim_next;
  tick_t   pres_next;
  tick_t   prev_tick;

  sched_result_t pending[$];
  int            errors = 0;
  int            idle_cycles = 0;
  bit            no_gaps = 1'b0;
  tick_t         tick_now = '0;

  dual_periodic_deadline_scheduler uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .current_tick (current_tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .elapsed_ticks(elapsed_ticks),
    .sim_due      (sim_due),
    .sim_missed   (sim_missed),
    .pres_due     (pres_due),
    .pres_missed  (pres_missed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Requested interval to period: zero becomes one, anything past four saturates
  function automatic period_t limit_period(input raw_t raw);
    return (raw == '0) ? PERIOD_MIN : ((raw >= raw_t'(PERIOD_MAX)) ? PERIOD_MAX : period_t'(raw));
  endfunction

  // One schedule on advance: due when now has reached the deadline (signed wrap)
  function automatic void serve_deadline(inout tick_t deadline, input period_t per,
                                         input tick_t now, output logic due,
                                         output tick_t missed);
    tick_t lag;
    lag = now - deadline;
    if (lag[TICK_W-1]) begin
      due = 1'b0;
      missed = '0;
    end else begin
      missed = lag / tick_t'(per);
      deadline = deadline + (missed + 1) * tick_t'(per);
      due = 1'b1;
    end
  endfunction

  // Expected result of one item; updates the predictor state
  function automatic sched_result_t schedule_step(input cmd_t cmd, input tick_t now);
    sched_result_t r;
    period_t p;
    r = '0;
    case (cmd)
      CMD_ADVANCE: begin
        r.elapsed = now - prev_tick;
        prev_tick = now;
        serve_deadline(sim_next, sim_per, now, r.sim_due, r.sim_missed);
        serve_deadline(pres_next, pres_per, now, r.pres_due, r.pres_missed);
      end
      CMD_INIT: begin
        sim_per = limit_period(sim_raw_q);
        pres_per = limit_period(pres_raw_q);
        sim_next = now + tick_t'(sim_per);
        pres_next = now + tick_t'(pres_per);
        prev_tick = now;
      end
      CMD_APPLY: begin
        // only a schedule whose period actually changes restarts
        p = limit_period(sim_raw_q);
        if (p != sim_per) begin
          sim_per = p;
          sim_next = now + tick_t'(p);
        end
        p = limit_period(pres_raw_q);
        if (p != pres_per) begin
          pres_per = p;
          pres_next = now + tick_t'(p);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Idle length drawn from three bands: mostly the shortest, now and then the longest
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 92) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Raw interval with weight on zero, the legal range and values past the clamp
  function automatic raw_t pick_raw();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r <= 4) begin
      return raw_t'(r);
    end else if (r == 5) begin
      return '1;
    end
    return raw_t'($urandom_range(0, 255));
  endfunction

  // Next tick: mostly small steps, some big jumps, steps back and wild values
  function automatic tick_t pick_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return tick_now + tick_t'($urandom_range(0, 9));
    end else if (r < 87) begin
      return tick_now + tick_t'($urandom_range(10, 200));
    end else if (r < 93) begin
      return tick_now + tick_t'($urandom);
    end else if (r < 97) begin
      return tick_now - tick_t'($urandom_range(1, 8));
    end
    return tick_t'($urandom);
  endfunction

  function automatic dir_row_t item_row(input cmd_t cmd, input tick_t tick);
    dir_row_t row;
    row = '{ROW_ITEM, cmd, tick, '0, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic dir_row_t typed_row(input cmd_t cmd, input tick_t tick,
                                         input sched_result_t want);
    dir_row_t row;
    row = '{ROW_ITEM, cmd, tick, '0, '0, 1'b1, want};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input raw_t sim_raw, input raw_t pres_raw);
    dir_row_t row;
    row = '{ROW_CFG, CMD_NOP, '0, sim_raw, pres_raw, 1'b0, '0};
    return row;
  endfunction

  // Present one item after an optional gap; record its expectation on acceptance
  task automatic send_item(input cmd_t cmd, input tick_t tick, input bit typed,
                           input sched_result_t want);
    int gap;
    sched_result_t predicted;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 99) >= 55) begin
      gap = idle_len();
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    current_tick <= tick;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = schedule_step(cmd, tick);
    pending.push_back(typed ? want : predicted);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain();
    item_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // Write both interval registers while the block is idle
  task automatic write_cfg(input raw_t sim_raw, input raw_t pres_raw);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SIM_INTERVAL;
    cfg_data <= sim_raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sim_raw_q = sim_raw;
    cfg_index <= CFG_PRES_INTERVAL;
    cfg_data <= pres_raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pres_raw_q = pres_raw;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input tick_t want, input tick_t got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result elapsed %h", $time, elapsed_ticks);
      end else begin
        want = pending.pop_front();
        check_field("elapsed_ticks", want.elapsed, elapsed_ticks);
        check_field("sim_due", tick_t'(want.sim_due), tick_t'(sim_due));
        check_field("sim_missed", want.sim_missed, sim_missed);
        check_field("pres_due", tick_t'(want.pres_due), tick_t'(pres_due));
        check_field("pres_missed", want.pres_missed, pres_missed);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result-side backpressure: free stretches, short stalls and a few long ones
  initial begin
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(20, 100)) @(posedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Main sequence
  initial begin
    dir_row_t rows[$];
    cmd_t cmd;
    int r;

    rst <= 1'b1;
    item_valid <= 1'b0;
    command <= CMD_ADVANCE;
    current_tick <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SIM_INTERVAL;
    cfg_data <= '0;
    sim_raw_q = 8'd1;
    pres_raw_q = 8'd1;
    sim_per = PERIOD_MIN;
    pres_per = PERIOD_MIN;
    sim_next = 32'd1;
    pres_next = 32'd1;
    prev_tick = '0;

    // Directed table: reset state, wrap, clamp extremes, restart rules, no-op code
    rows.push_back(typed_row(CMD_ADVANCE, 32'h0000_0000, '0));
    rows.push_back(typed_row(CMD_ADVANCE, 32'h0000_0001,
                             {32'd1, 1'b1, 32'd0, 1'b1, 32'd0}));
    rows.push_back(typed_row(CMD_ADVANCE, 32'h0000_0005,
                             {32'd4, 1'b1, 32'd3, 1'b1, 32'd3}));
    rows.push_back(typed_row(CMD_NOP, 32'hFFFF_FFFF, '0));
    rows.push_back(typed_row(CMD_ADVANCE, 32'h8000_0005,
                             {32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF}));
    rows.push_back(typed_row(CMD_ADVANCE, 32'h8000_0005, '0));
    rows.push_back(cfg_row(8'd0, 8'd255));
    rows.push_back(typed_row(CMD_APPLY, 32'h0000_0010, '0));
    rows.push_back(typed_row(CMD_INIT, 32'hFFFF_FFFE, '0));
    rows.push_back(item_row(CMD_ADVANCE, 32'hFFFF_FFFF));
    rows.push_back(item_row(CMD_ADVANCE, 32'h0000_0003));
    rows.push_back(item_row(CMD_ADVANCE, 32'h0000_0003));
    rows.push_back(cfg_row(8'd3, 8'd2));
    rows.push_back(item_row(CMD_APPLY, 32'd10));
    rows.push_back(item_row(CMD_ADVANCE, 32'd9));
    rows.push_back(item_row(CMD_ADVANCE, 32'd20));
    rows.push_back(cfg_row(8'd4, 8'd5));
    rows.push_back(item_row(CMD_APPLY, 32'd20));
    rows.push_back(cfg_row(8'd4, 8'd4));
    rows.push_back(item_row(CMD_APPLY, 32'd30));
    rows.push_back(item_row(CMD_ADVANCE, 32'h7FFF_FFF0));
    rows.push_back(typed_row(CMD_INIT, 32'd0, '0));
    rows.push_back(typed_row(CMD_NOP, 32'h1234_5678, '0));
    rows.push_back(item_row(CMD_ADVANCE, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(8'd2, 8'd1));
    rows.push_back(item_row(CMD_INIT, 32'd100));
    rows.push_back(item_row(CMD_ADVANCE, 32'd101));
    rows.push_back(item_row(CMD_ADVANCE, 32'd102));
    rows.push_back(typed_row(CMD_APPLY, 32'hAAAA_AAAA, '0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_cfg(rows[i].sim_raw, rows[i].pres_raw);
      end else begin
        send_item(rows[i].cmd, rows[i].tick, rows[i].typed, rows[i].want);
      end
    end
    tick_now = 32'd102;

    // Random phases: new intervals, a restart, then mostly advances
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_cfg(pick_raw(), pick_raw());
      no_gaps = ($urandom_range(0, 3) == 0);
      tick_now = pick_tick();
      send_item(($urandom_range(0, 1) != 0) ? CMD_INIT : CMD_APPLY, tick_now, 1'b0, '0);
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 74) begin
          cmd = CMD_ADVANCE;
        end else if (r < 84) begin
          cmd = CMD_INIT;
        end else if (r < 95) begin
          cmd = CMD_APPLY;
        end else begin
          cmd = CMD_NOP;
        end
        tick_now = pick_tick();
        send_item(cmd, tick_now, 1'b0, '0);
      end
    end
    no_gaps = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
